### hdl/erq_pkg.sv
// Shared types, widths and codes for the extremum removal queue.
`timescale 1ns / 1ps

package erq_pkg;

  // Store geometry.
  localparam int CAPACITY = 64;
  localparam int IDX_W    = $clog2(CAPACITY);
  localparam int CNT_W    = $clog2(CAPACITY + 1);

  // Field widths fixed by the interface.
  localparam int VAL_W    = 31;
  localparam int IN_W     = 32;
  localparam int STAT_W   = 3;
  localparam int OCC_W    = 7;

  // Command codes.
  localparam logic CMD_INSERT = 1'b0;
  localparam logic CMD_REMOVE = 1'b1;

  // Result status codes.
  typedef enum logic [STAT_W-1:0] {
    ST_INSERTED = 3'd0,
    ST_NEGATIVE = 3'd1,
    ST_FULL     = 3'd2,
    ST_REMOVED  = 3'd3,
    ST_EMPTY    = 3'd4
  } status_e;

  // Controller states.
  typedef enum logic [1:0] {
    FSM_IDLE,
    FSM_SCAN,
    FSM_COMPACT,
    FSM_FINISH
  } state_e;

  // Operation broadcast to every cell of the chain.
  typedef enum logic [1:0] {
    OP_HOLD,
    OP_LOAD,
    OP_ROTATE,
    OP_DROP
  } cell_op_e;

  typedef struct packed {
    cell_op_e           op;
    logic [IDX_W-1:0]   pos;
    logic [VAL_W-1:0]   data;
  } cell_ctrl_t;

  // Input transaction payload.
  typedef struct packed {
    logic               cmd;
    logic signed [IN_W-1:0] value;
  } in_item_t;

  // Output transaction payload.
  typedef struct packed {
    logic [VAL_W-1:0]   removed_value;
    logic [STAT_W-1:0]  status;
    logic [OCC_W-1:0]   occupancy;
  } out_item_t;

endpackage

### hdl/erq_cell.sv
// One storage cell of the entry chain.
`timescale 1ns / 1ps

module erq_cell (
  input  logic                              clk_i,
  input  logic [erq_pkg::IDX_W-1:0]         idx_i,
  input  erq_pkg::cell_ctrl_t               ctrl_i,
  input  logic [erq_pkg::VAL_W-1:0]         next_i,
  input  logic [erq_pkg::VAL_W-1:0]         head_i,
  output logic [erq_pkg::VAL_W-1:0]         data_o
);

  logic [erq_pkg::VAL_W-1:0] data_q, data_d;

  // Cells below the tail position shift toward the head. The tail cell takes
  // the head entry on a rotation and keeps its word on a drop.
  always_comb begin
    data_d = data_q;
    case (ctrl_i.op)
      erq_pkg::OP_LOAD: begin
        if (idx_i == ctrl_i.pos) begin
          data_d = ctrl_i.data;
        end
      end
      erq_pkg::OP_ROTATE: begin
        if (idx_i < ctrl_i.pos) begin
          data_d = next_i;
        end else if (idx_i == ctrl_i.pos) begin
          data_d = head_i;
        end
      end
      erq_pkg::OP_DROP: begin
        if (idx_i < ctrl_i.pos) begin
          data_d = next_i;
        end
      end
      default: begin
        data_d = data_q;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign data_o = data_q;

endmodule

### hdl/erq_ctrl.sv
// Command sequencer, extremum tracker and result register of the queue.
`timescale 1ns / 1ps

module erq_ctrl (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  erq_pkg::in_item_t             in_data_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output erq_pkg::out_item_t            out_data_o,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic                          cfg_data_i,
  input  logic [erq_pkg::VAL_W-1:0]     head_i,
  output erq_pkg::cell_ctrl_t           cell_ctrl_o
);

  erq_pkg::state_e               state_q, state_d;
  logic [erq_pkg::CNT_W-1:0]     count_q, count_d;
  logic                          mode_q;
  logic [erq_pkg::VAL_W-1:0]     value_q, value_d;
  erq_pkg::status_e              status_q, status_d;
  logic [erq_pkg::IDX_W-1:0]     step_q, step_d;
  logic [erq_pkg::IDX_W-1:0]     pick_q, pick_d;
  logic [erq_pkg::IDX_W-1:0]     last_q, last_d;
  logic [erq_pkg::VAL_W-1:0]     best_q, best_d;
  logic                          out_valid_q, out_valid_d;
  erq_pkg::out_item_t            out_q, out_d;

  logic                          in_fire;
  logic                          slot_free;
  logic                          better;
  logic [erq_pkg::IDX_W-1:0]     tail_pos;

  assign in_fire     = in_valid_i && !in_stall_o;
  assign slot_free   = !out_valid_q || !out_stall_i;
  assign in_stall_o  = (state_q != erq_pkg::FSM_IDLE);
  assign cfg_ready_o = 1'b1;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;
  assign tail_pos    = count_q[erq_pkg::IDX_W-1:0] - {{(erq_pkg::IDX_W-1){1'b0}}, 1'b1};

  // The mode register picks which way the running comparison goes.
  assign better = mode_q ? (head_i < best_q) : (head_i > best_q);

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      erq_pkg::FSM_IDLE: begin
        if (in_fire) begin
          if (in_data_i.cmd == erq_pkg::CMD_REMOVE && count_q != '0) begin
            state_d = erq_pkg::FSM_SCAN;
          end else begin
            state_d = erq_pkg::FSM_FINISH;
          end
        end
      end
      erq_pkg::FSM_SCAN: begin
        if (step_q == last_q) begin
          state_d = erq_pkg::FSM_COMPACT;
        end
      end
      erq_pkg::FSM_COMPACT: begin
        if (step_q == last_q) begin
          state_d = erq_pkg::FSM_FINISH;
        end
      end
      erq_pkg::FSM_FINISH: begin
        if (slot_free) begin
          state_d = erq_pkg::FSM_IDLE;
        end
      end
      default: begin
        state_d = erq_pkg::FSM_IDLE;
      end
    endcase
  end

  // Datapath and cell control for each state.
  always_comb begin
    count_d          = count_q;
    value_d          = value_q;
    status_d         = status_q;
    step_d           = step_q;
    pick_d           = pick_q;
    last_d           = last_q;
    best_d           = best_q;
    out_valid_d      = out_valid_q && out_stall_i;
    out_d            = out_q;
    cell_ctrl_o.op   = erq_pkg::OP_HOLD;
    cell_ctrl_o.pos  = tail_pos;
    cell_ctrl_o.data = value_q;
    unique case (state_q)
      erq_pkg::FSM_IDLE: begin
        // Decide the outcome of the transaction from the present fill level.
        if (in_fire) begin
          value_d = in_data_i.value[erq_pkg::VAL_W-1:0];
          step_d  = '0;
          last_d  = tail_pos;
          if (in_data_i.cmd == erq_pkg::CMD_INSERT) begin
            if (in_data_i.value[erq_pkg::IN_W-1]) begin
              status_d = erq_pkg::ST_NEGATIVE;
            end else if (count_q >= (erq_pkg::CNT_W)'(erq_pkg::CAPACITY)) begin
              status_d = erq_pkg::ST_FULL;
            end else begin
              status_d = erq_pkg::ST_INSERTED;
            end
          end else if (count_q == '0) begin
            status_d = erq_pkg::ST_EMPTY;
          end else begin
            status_d = erq_pkg::ST_REMOVED;
          end
        end
      end
      erq_pkg::FSM_SCAN: begin
        // One full turn of the occupied cells; entry number step sits at the head.
        cell_ctrl_o.op = erq_pkg::OP_ROTATE;
        if (step_q == '0 || better) begin
          best_d = head_i;
          pick_d = step_q;
        end
        step_d = (step_q == last_q) ? '0 : step_q + 1'b1;
      end
      erq_pkg::FSM_COMPACT: begin
        // A second turn that drops the chosen entry as it passes the head.
        if (step_q == pick_q) begin
          cell_ctrl_o.op = erq_pkg::OP_DROP;
          count_d        = count_q - 1'b1;
        end else begin
          cell_ctrl_o.op = erq_pkg::OP_ROTATE;
        end
        step_d = step_q + 1'b1;
      end
      erq_pkg::FSM_FINISH: begin
        // Commit an insert and register the result once the output is free.
        if (slot_free) begin
          if (status_q == erq_pkg::ST_INSERTED) begin
            cell_ctrl_o.op  = erq_pkg::OP_LOAD;
            cell_ctrl_o.pos = count_q[erq_pkg::IDX_W-1:0];
            count_d         = count_q + 1'b1;
          end
          out_valid_d         = 1'b1;
          out_d.removed_value = (status_q == erq_pkg::ST_REMOVED) ? best_q : '0;
          out_d.status        = status_q;
          out_d.occupancy     = (erq_pkg::OCC_W)'(count_d);
        end
      end
      default: begin
        cell_ctrl_o.op = erq_pkg::OP_HOLD;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= erq_pkg::FSM_IDLE;
      count_q     <= '0;
      mode_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
      if (cfg_valid_i && cfg_ready_o) begin
        mode_q <= cfg_data_i;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    value_q  <= value_d;
    status_q <= status_d;
    step_q   <= step_d;
    pick_q   <= pick_d;
    last_q   <= last_d;
    best_q   <= best_d;
    out_q    <= out_d;
  end

  // The fill level never passes the capacity.
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= (erq_pkg::CNT_W)'(erq_pkg::CAPACITY))
    else $error("queue fill level beyond capacity");

  // An accepted transaction always leaves the idle state.
  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |=> state_q != erq_pkg::FSM_IDLE)
    else $error("accepted transaction was not started");

  // The step counter stays inside the occupied range while scanning.
  a_scan_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == erq_pkg::FSM_SCAN |-> step_q <= last_q)
    else $error("scan step past the last entry");

  // Dropping the chosen entry takes exactly one entry out.
  a_drop_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == erq_pkg::FSM_COMPACT && step_q == pick_q)
      |=> count_q == $past(count_q) - 1'b1)
    else $error("compaction did not remove one entry");

  // A result is only registered on the way out of the finish state.
  a_result_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q) == erq_pkg::FSM_FINISH)
    else $error("result registered outside the finish state");

endmodule

### hdl/extremum_removal_queue.sv
// Top level of the extremum removal queue: cell chain plus sequencer.
// Insert, ignored, full and empty results pass through the finish state to the
// output register; a remove over n held entries first passes through the scan
// and compaction states, the two full turns of the rotating cell chain. A new
// transaction is taken only once the last result is registered.
// Reset clears the fill level, mode and output valid; entry words are not
// cleared and no clearing pass runs, so the queue is ready right after reset.
`timescale 1ns / 1ps

module extremum_removal_queue (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  erq_pkg::in_item_t     in_data_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output erq_pkg::out_item_t    out_data_o,
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic                  cfg_data_i
);

  erq_pkg::cell_ctrl_t        cell_ctrl;
  logic [erq_pkg::VAL_W-1:0]  cell_data [erq_pkg::CAPACITY];

  // Sequencer, comparison and result register.
  erq_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_data_i  (cfg_data_i),
    .head_i      (cell_data[0]),
    .cell_ctrl_o (cell_ctrl)
  );

  // Chain of entry cells; each one shifts toward the head from its neighbor.
  for (genvar g = 0; g < erq_pkg::CAPACITY; g++) begin : g_cell
    logic [erq_pkg::VAL_W-1:0] next_data;
    if (g == erq_pkg::CAPACITY - 1) begin : g_end
      assign next_data = cell_data[g];
    end else begin : g_mid
      assign next_data = cell_data[g+1];
    end
    erq_cell u_cell (
      .clk_i  (clk_i),
      .idx_i  ((erq_pkg::IDX_W)'(g)),
      .ctrl_i (cell_ctrl),
      .next_i (next_data),
      .head_i (cell_data[0]),
      .data_o (cell_data[g])
    );
  end

endmodule
